>>> sv/moh_pkg.sv
// ----------------------------------------------------------------------------
// moh_pkg
// Shared types and constants of the orbit density histogram: controller
// states, command and status bundles, register map and field widths.
// ----------------------------------------------------------------------------
package moh_pkg;

    localparam int Z_W    = 32;
    localparam int STEP_W = 17;
    localparam int OUT_W  = 32;

    typedef enum logic [2:0] {
        REG_MAX_ITER   = 3'd0,
        REG_ESCAPE     = 3'd1,
        REG_X_ORIGIN   = 3'd2,
        REG_Y_ORIGIN   = 3'd3,
        REG_X_SCALE    = 3'd4,
        REG_Y_SCALE    = 3'd5
    } moh_reg_t;

    localparam logic [STEP_W-1:0] MAX_ITER_RST = STEP_W'(100000);
    localparam logic [31:0]       ESCAPE_RST   = 32'd268435456;
    localparam logic [31:0]       X_ORIGIN_RST = 32'hF800_0000;
    localparam logic [31:0]       Y_ORIGIN_RST = 32'hFA00_0000;
    localparam logic [31:0]       X_SCALE_RST  = 32'd5570560;
    localparam logic [31:0]       Y_SCALE_RST  = 32'd5222400;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_MULTIPLY,
        ST_LOOK,
        ST_BUMP,
        ST_FETCH,
        ST_FINISH
    } moh_state_t;

    typedef struct packed {
        logic start;
        logic clear;
        logic update;
        logic multiply;
        logic look;
        logic bump;
        logic fetch;
        logic finish;
    } moh_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic stop;
    } moh_status_t;

endpackage

>>> sv/mandelbrot_orbit_histogram.sv
// ----------------------------------------------------------------------------
// mandelbrot_orbit_histogram
// Orbit density histogram: iterates z = z^2 + c per request, counts the
// grid bins the orbit visits, and reads back single bin counts.
//
//   channel   ports                       direction  carries
//   s_        s_valid/s_ready + fields    in         orbit or bin read request
//   m_        m_valid/m_ready + fields    out        steps, escape flag, count
//   apb       psel/penable/pwrite/...     in         six configuration registers
//
// Each orbit step is one update, one multiply and one bin read-modify-write
// on the single-port counter memory. After reset the counter memory is
// swept to zero with s_ready low; configuration writes are taken meanwhile.
// A request is taken while an earlier result waits; the block then holds
// its next result until m_ready frees the result register.
// ----------------------------------------------------------------------------
module mandelbrot_orbit_histogram
    import moh_pkg::*;
#(
    parameter int GRID_WIDTH    = 256,
    parameter int GRID_HEIGHT   = 256,
    parameter int COUNT_BITS    = 32,
    parameter int FRACTION_BITS = 26
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_operation,
    input  logic [Z_W-1:0]    s_c_real,
    input  logic [Z_W-1:0]    s_c_imag,
    input  logic [7:0]        s_bin_column,
    input  logic [7:0]        s_bin_row,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [STEP_W-1:0] m_steps_taken,
    output logic              m_escaped,
    output logic [OUT_W-1:0]  m_bin_count
);

    logic [STEP_W-1:0] max_iter_reg;
    logic [31:0]       escape_reg;
    logic [31:0]       x_origin_reg;
    logic [31:0]       y_origin_reg;
    logic [31:0]       x_scale_reg;
    logic [31:0]       y_scale_reg;
    logic              wr_en;
    moh_reg_t          reg_sel;
    moh_cmd_t          cmd;
    moh_status_t       status;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = moh_reg_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_iter_reg <= MAX_ITER_RST;
            escape_reg   <= ESCAPE_RST;
            x_origin_reg <= X_ORIGIN_RST;
            y_origin_reg <= Y_ORIGIN_RST;
            x_scale_reg  <= X_SCALE_RST;
            y_scale_reg  <= Y_SCALE_RST;
        end else if (wr_en) begin
            case (reg_sel)
                REG_MAX_ITER: max_iter_reg <= pwdata[STEP_W-1:0];
                REG_ESCAPE:   escape_reg   <= pwdata;
                REG_X_ORIGIN: x_origin_reg <= pwdata;
                REG_Y_ORIGIN: y_origin_reg <= pwdata;
                REG_X_SCALE:  x_scale_reg  <= pwdata;
                REG_Y_SCALE:  y_scale_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_MAX_ITER: prdata = 32'(max_iter_reg);
            REG_ESCAPE:   prdata = escape_reg;
            REG_X_ORIGIN: prdata = x_origin_reg;
            REG_Y_ORIGIN: prdata = y_origin_reg;
            REG_X_SCALE:  prdata = x_scale_reg;
            REG_Y_SCALE:  prdata = y_scale_reg;
            default:      prdata = '0;
        endcase
    end

    moh_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_operation (s_operation),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .status      (status)
    );

    moh_datapath #(
        .GRID_WIDTH    (GRID_WIDTH),
        .GRID_HEIGHT   (GRID_HEIGHT),
        .COUNT_BITS    (COUNT_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .max_iterations (max_iter_reg),
        .escape_norm_sq (escape_reg),
        .x_origin       (x_origin_reg),
        .y_origin       (y_origin_reg),
        .x_scale        (x_scale_reg),
        .y_scale        (y_scale_reg),
        .s_operation    (s_operation),
        .s_c_real       (s_c_real),
        .s_c_imag       (s_c_imag),
        .s_bin_column   (s_bin_column),
        .s_bin_row      (s_bin_row),
        .cmd            (cmd),
        .status         (status),
        .m_steps_taken  (m_steps_taken),
        .m_escaped      (m_escaped),
        .m_bin_count    (m_bin_count)
    );

endmodule

>>> sv/moh_ctrl.sv
// ----------------------------------------------------------------------------
// moh_ctrl
// Sequencer: clearing sweep after reset, request intake, the orbit step loop,
// bin fetch, and the result register handshake.
// ----------------------------------------------------------------------------
module moh_ctrl
    import moh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_operation,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output moh_cmd_t    cmd,
    input  moh_status_t status
);

    moh_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = s_operation ? ST_FETCH : ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_MULTIPLY;
            end
            ST_MULTIPLY: begin
                cmd.multiply = 1'b1;
                state_next   = ST_LOOK;
            end
            ST_LOOK: begin
                cmd.look   = 1'b1;
                state_next = ST_BUMP;
            end
            ST_BUMP: begin
                cmd.bump = 1'b1;
                if (status.stop) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.update = 1'b1;
                    state_next = ST_MULTIPLY;
                end
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

>>> sv/moh_datapath.sv
// ----------------------------------------------------------------------------
// moh_datapath
// Orbit arithmetic, bin mapping, bin counter memory with clearing sweep,
// and the result payload register.
// ----------------------------------------------------------------------------
module moh_datapath
    import moh_pkg::*;
#(
    parameter int GRID_WIDTH    = 256,
    parameter int GRID_HEIGHT   = 256,
    parameter int COUNT_BITS    = 32,
    parameter int FRACTION_BITS = 26
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [STEP_W-1:0] max_iterations,
    input  logic [31:0]       escape_norm_sq,
    input  logic [31:0]       x_origin,
    input  logic [31:0]       y_origin,
    input  logic [31:0]       x_scale,
    input  logic [31:0]       y_scale,
    input  logic              s_operation,
    input  logic [Z_W-1:0]    s_c_real,
    input  logic [Z_W-1:0]    s_c_imag,
    input  logic [7:0]        s_bin_column,
    input  logic [7:0]        s_bin_row,
    input  moh_cmd_t          cmd,
    output moh_status_t       status,
    output logic [STEP_W-1:0] m_steps_taken,
    output logic              m_escaped,
    output logic [OUT_W-1:0]  m_bin_count
);

    localparam int BIN_TOTAL = GRID_WIDTH * GRID_HEIGHT;
    localparam int ADDR_W    = $clog2(BIN_TOTAL);
    localparam int XB_W      = $clog2(GRID_WIDTH);
    localparam int YB_W      = $clog2(GRID_HEIGHT);
    localparam int QLO       = FRACTION_BITS + 16;
    localparam int Q_W       = 64 - QLO;
    localparam int NRM_SH    = 2 * FRACTION_BITS - 24;

    function automatic logic [Z_W-1:0] sat_z(input logic [64:0] v);
        logic in_range;
        in_range = (&v[64:31]) | ~(|v[64:31]);
        if (in_range) begin
            return v[31:0];
        end
        return v[64] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    logic [COUNT_BITS-1:0] mem [BIN_TOTAL];

    logic                     op_reg;
    logic signed [Z_W-1:0]    c_re_reg, c_im_reg;
    logic [7:0]               col_reg, row_reg;
    logic signed [Z_W-1:0]    z_re_reg, z_im_reg;
    logic [STEP_W-1:0]        steps_reg;
    logic signed [63:0]       xx_reg, yy_reg, xy_reg;
    logic [63:0]              px_reg, py_reg;
    logic                     x_neg_reg, y_neg_reg;
    logic [ADDR_W-1:0]        addr_reg;
    logic                     hit_reg;
    logic                     esc_reg;
    logic                     stop_reg;
    logic [COUNT_BITS-1:0]    rd_data_reg;
    logic [ADDR_W-1:0]        clr_cnt_reg;
    logic [STEP_W-1:0]        out_steps_reg;
    logic                     out_esc_reg;
    logic [OUT_W-1:0]         out_count_reg;

    // z update
    logic signed [63:0] re_diff, re_shift, im_shift;
    logic [64:0]        re_wide, im_wide;
    logic [Z_W-1:0]     z_re_next, z_im_next;

    assign re_diff  = xx_reg - yy_reg;
    assign re_shift = re_diff >>> FRACTION_BITS;
    assign im_shift = xy_reg >>> (FRACTION_BITS - 1);
    assign re_wide  = {re_shift[63], re_shift} + {{33{c_re_reg[31]}}, c_re_reg};
    assign im_wide  = {im_shift[63], im_shift} + {{33{c_im_reg[31]}}, c_im_reg};
    assign z_re_next = sat_z(re_wide);
    assign z_im_next = sat_z(im_wide);

    // squares and scale products
    logic signed [63:0] xx_next, yy_next, xy_next;
    logic [32:0]        dx, dy;
    logic [63:0]        px_next, py_next;

    assign xx_next = z_re_reg * z_re_reg;
    assign yy_next = z_im_reg * z_im_reg;
    assign xy_next = z_re_reg * z_im_reg;
    assign dx      = {z_re_reg[31], z_re_reg} - {x_origin[31], x_origin};
    assign dy      = {z_im_reg[31], z_im_reg} - {y_origin[31], y_origin};
    assign px_next = dx[31:0] * x_scale;
    assign py_next = dy[31:0] * y_scale;

    // bin lookup
    logic [Q_W-1:0]    qx, qy;
    logic [XB_W-1:0]   bi;
    logic [YB_W-1:0]   bj;
    logic              x_hit, y_hit;
    logic [ADDR_W-1:0] bin_addr, fetch_addr, rd_addr;
    logic [63:0]       nrm;
    logic              esc_now;
    logic              fetch_hit;

    assign qx    = px_reg[63:QLO];
    assign qy    = py_reg[63:QLO];
    assign x_hit = (x_scale == '0) || (!x_neg_reg && (qx < Q_W'(GRID_WIDTH)));
    assign y_hit = (y_scale == '0) || (!y_neg_reg && (qy < Q_W'(GRID_HEIGHT)));
    assign bi    = (x_scale == '0) ? '0 : qx[XB_W-1:0];
    assign bj    = (y_scale == '0) ? '0 : qy[YB_W-1:0];

    assign bin_addr   = ADDR_W'(bj) * ADDR_W'(GRID_WIDTH) + ADDR_W'(bi);
    assign fetch_addr = ADDR_W'(row_reg) * ADDR_W'(GRID_WIDTH) + ADDR_W'(col_reg);
    assign rd_addr    = cmd.fetch ? fetch_addr : bin_addr;
    assign fetch_hit  = (32'(col_reg) < 32'(GRID_WIDTH)) && (32'(row_reg) < 32'(GRID_HEIGHT));

    assign nrm     = xx_reg + yy_reg;
    assign esc_now = (nrm >> NRM_SH) >= 64'(escape_norm_sq);

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg   <= s_operation;
            c_re_reg <= s_c_real;
            c_im_reg <= s_c_imag;
            col_reg  <= s_bin_column;
            row_reg  <= s_bin_row;
            z_re_reg <= '0;
            z_im_reg <= '0;
            steps_reg <= '0;
            xx_reg   <= '0;
            yy_reg   <= '0;
            xy_reg   <= '0;
        end
        if (cmd.update) begin
            z_re_reg  <= z_re_next;
            z_im_reg  <= z_im_next;
            steps_reg <= steps_reg + 1'b1;
        end
        if (cmd.multiply) begin
            xx_reg    <= xx_next;
            yy_reg    <= yy_next;
            xy_reg    <= xy_next;
            px_reg    <= px_next;
            py_reg    <= py_next;
            x_neg_reg <= dx[32];
            y_neg_reg <= dy[32];
        end
        if (cmd.look) begin
            addr_reg <= bin_addr;
            hit_reg  <= x_hit && y_hit;
            esc_reg  <= esc_now;
            stop_reg <= esc_now || (steps_reg >= max_iterations);
        end
        if (cmd.finish) begin
            if (op_reg) begin
                out_steps_reg <= '0;
                out_esc_reg   <= 1'b0;
                out_count_reg <= fetch_hit ? OUT_W'(rd_data_reg) : '0;
            end else begin
                out_steps_reg <= steps_reg;
                out_esc_reg   <= esc_reg;
                out_count_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.look || cmd.fetch) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (cmd.clear) begin
            mem[clr_cnt_reg] <= '0;
        end else if (cmd.bump && hit_reg) begin
            mem[addr_reg] <= (&rd_data_reg) ? rd_data_reg : rd_data_reg + 1'b1;
        end
    end

    assign status.clear_last = (clr_cnt_reg == ADDR_W'(BIN_TOTAL - 1));
    assign status.stop       = stop_reg;

    assign m_steps_taken = out_steps_reg;
    assign m_escaped     = out_esc_reg;
    assign m_bin_count   = out_count_reg;

endmodule

>>> tb/tb_mandelbrot_orbit_histogram.sv
// ----------------------------------------------------------------------------
// tb_mandelbrot_orbit_histogram
// Self-checking bench for the orbit density histogram. Orbit and bin read
// requests go in over the s_ channel with random gaps. The six registers are
// set over APB between phases. A local bit-exact model iterates each orbit,
// keeps its own copy of the bin counters, and queues one expected result per
// accepted request. Each result taken from the m_ channel, under random
// back-pressure, is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module tb_mandelbrot_orbit_histogram;
    import moh_pkg::*;

    localparam int HIST_COLS   = 256;
    localparam int HIST_ROWS   = 256;
    localparam int HIST_BINS   = HIST_COLS * HIST_ROWS;
    localparam int FRAC        = 26;
    localparam int STALL_LIMIT = 400000;

    localparam logic OP_ORBIT = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    localparam longint Z_HI = 64'sd2147483647;
    localparam longint Z_LO = -64'sd2147483648;

    localparam logic [31:0] Q_ONE         = 32'h0400_0000;
    localparam logic [31:0] Q_QUARTER     = 32'h0100_0000;
    localparam logic [31:0] Q_MINUS_TWO   = 32'hF800_0000;
    localparam logic [31:0] Q_MINUS_THREE = 32'hF400_0000;
    localparam logic [31:0] Z_MAX_POS     = 32'h7FFF_FFFF;
    localparam logic [31:0] Z_MAX_NEG     = 32'h8000_0000;
    localparam logic [31:0] ESC_SIXTEEN   = 32'h1000_0000;
    localparam logic [31:0] ESC_FOUR      = 32'h0400_0000;

    typedef struct packed {
        logic [STEP_W-1:0] steps;
        logic              escaped;
        logic [OUT_W-1:0]  count;
    } orbit_result_t;

    logic              aclk;
    logic              aresetn;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [4:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_valid;
    logic              s_ready;
    logic              s_operation;
    logic [Z_W-1:0]    s_c_real;
    logic [Z_W-1:0]    s_c_imag;
    logic [7:0]        s_bin_column;
    logic [7:0]        s_bin_row;
    logic              m_valid;
    logic              m_ready;
    logic [STEP_W-1:0] m_steps_taken;
    logic              m_escaped;
    logic [OUT_W-1:0]  m_bin_count;

    logic [STEP_W-1:0] cfg_max_iter;
    logic [31:0]       cfg_escape;
    logic [31:0]       cfg_x_origin;
    logic [31:0]       cfg_y_origin;
    logic [31:0]       cfg_x_scale;
    logic [31:0]       cfg_y_scale;

    logic [OUT_W-1:0]  bin_hist [HIST_BINS];
    int                visited_bins[$];
    orbit_result_t     expected_results[$];
    int                mismatches;
    int                stall_cycles;
    bit                steady;

    mandelbrot_orbit_histogram DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_c_real      (s_c_real),
        .s_c_imag      (s_c_imag),
        .s_bin_column  (s_bin_column),
        .s_bin_row     (s_bin_row),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_steps_taken (m_steps_taken),
        .m_escaped     (m_escaped),
        .m_bin_count   (m_bin_count)
    );

    always #10 aclk = ~aclk;

    function automatic longint clamp32(longint v);
        if (v > Z_HI) return Z_HI;
        if (v < Z_LO) return Z_LO;
        return v;
    endfunction

    function automatic logic map_axis(longint pos, logic [31:0] origin, logic [31:0] scale,
                                      int span, output int bin);
        longint      diff;
        logic [65:0] prod;
        bin  = 0;
        diff = pos - longint'($signed(origin));
        if (scale == '0) return 1'b1;
        if (diff < 0) return 1'b0;
        prod = diff;
        prod = prod * {34'd0, scale};
        prod = prod >> (FRAC + 16);
        if (prod >= span) return 1'b0;
        bin = int'(prod);
        return 1'b1;
    endfunction

    task automatic trace_orbit(input logic [31:0] cr, input logic [31:0] ci,
                               output logic [STEP_W-1:0] steps, output logic esc);
        longint            x;
        longint            y;
        longint            zr;
        longint            zi;
        logic [63:0]       norm;
        logic [STEP_W-1:0] n;
        logic              out_flag;
        logic              hit_c;
        logic              hit_r;
        int                col;
        int                row;
        int                idx;
        x = 0;
        y = 0;
        n = '0;
        do begin
            zr = clamp32(((x * x - y * y) >>> FRAC) + longint'($signed(cr)));
            zi = clamp32(((x * y) >>> (FRAC - 1)) + longint'($signed(ci)));
            n  = n + 1'b1;
            hit_c = map_axis(zr, cfg_x_origin, cfg_x_scale, HIST_COLS, col);
            hit_r = map_axis(zi, cfg_y_origin, cfg_y_scale, HIST_ROWS, row);
            if (hit_c && hit_r) begin
                idx = row * HIST_COLS + col;
                if (bin_hist[idx] == '0) visited_bins.push_back(idx);
                if (bin_hist[idx] != '1) bin_hist[idx] = bin_hist[idx] + 1'b1;
            end
            x = zr;
            y = zi;
            norm = x * x + y * y;
            out_flag = (norm >> (2 * FRAC - 24)) >= {32'd0, cfg_escape};
        end while (!out_flag && n < cfg_max_iter);
        steps = n;
        esc   = out_flag;
    endtask

    task automatic predict_result(input logic op, input logic [31:0] cr, input logic [31:0] ci,
                                  input logic [7:0] col, input logic [7:0] row,
                                  output orbit_result_t want);
        logic [STEP_W-1:0] steps;
        logic              esc;
        want = '0;
        if (op == OP_READ) begin
            want.count = bin_hist[int'(row) * HIST_COLS + int'(col)];
        end else begin
            trace_orbit(cr, ci, steps, esc);
            want.steps   = steps;
            want.escaped = esc;
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_MAX_ITER: cfg_max_iter = value[STEP_W-1:0];
            REG_ESCAPE:   cfg_escape   = value;
            REG_X_ORIGIN: cfg_x_origin = value;
            REG_Y_ORIGIN: cfg_y_origin = value;
            REG_X_SCALE:  cfg_x_scale  = value;
            REG_Y_SCALE:  cfg_y_scale  = value;
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic send_request(input logic op, input logic [31:0] cr, input logic [31:0] ci,
                                input logic [7:0] col, input logic [7:0] row);
        orbit_result_t want;
        while (!steady && $urandom_range(99) < 30) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_c_real     <= cr;
        s_c_imag     <= ci;
        s_bin_column <= col;
        s_bin_row    <= row;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_result(op, cr, ci, col, row, want);
        expected_results.push_back(want);
        @(negedge aclk);
    endtask

    task automatic orbit_point(input logic [31:0] cr, input logic [31:0] ci);
        send_request(OP_ORBIT, cr, ci, 8'($urandom), 8'($urandom));
    endtask

    task automatic read_bin(input logic [7:0] col, input logic [7:0] row);
        send_request(OP_READ, $urandom, $urandom, col, row);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic test_reset_defaults();
        orbit_point(Q_ONE, Q_ONE);
        orbit_point(Z_MAX_POS, Z_MAX_NEG);
        orbit_point(Z_MAX_NEG, Z_MAX_POS);
        read_bin(8'd255, 8'd199);
        read_bin(8'd0, 8'd0);
        read_bin(8'd255, 8'd255);
        drain_results();
    endtask

    task automatic test_iteration_cap();
        write_reg(REG_MAX_ITER, 32'd0);
        orbit_point(32'd0, 32'd0);
        drain_results();
        write_reg(REG_MAX_ITER, 32'd1);
        orbit_point(Q_MINUS_TWO, 32'd0);
        drain_results();
        write_reg(REG_MAX_ITER, 32'd37);
        orbit_point(32'd0, 32'd0);
        orbit_point(Q_MINUS_TWO, 32'd0);
        read_bin(8'd170, 8'd119);
        drain_results();
        write_reg(REG_MAX_ITER, 32'd131071);
        orbit_point(Z_MAX_POS, 32'd0);
        orbit_point(Q_MINUS_THREE, 32'd0);
        drain_results();
    endtask

    task automatic test_escape_limit();
        write_reg(REG_MAX_ITER, 32'd64);
        write_reg(REG_ESCAPE, 32'd0);
        orbit_point(32'd0, 32'd0);
        orbit_point(Q_MINUS_TWO, 32'd0);
        drain_results();
        write_reg(REG_ESCAPE, 32'hFFFF_FFFF);
        orbit_point(Q_ONE, Q_ONE);
        orbit_point(Q_MINUS_TWO, 32'd0);
        drain_results();
    endtask

    task automatic test_grid_mapping();
        write_reg(REG_ESCAPE, ESC_SIXTEEN);
        write_reg(REG_MAX_ITER, 32'd20);
        write_reg(REG_X_SCALE, 32'd0);
        write_reg(REG_Y_SCALE, 32'd0);
        orbit_point(Q_QUARTER, 32'd0);
        read_bin(8'd0, 8'd0);
        drain_results();
        write_reg(REG_X_SCALE, 32'hFFFF_FFFF);
        write_reg(REG_Y_SCALE, 32'hFFFF_FFFF);
        write_reg(REG_X_ORIGIN, Z_MAX_NEG);
        write_reg(REG_Y_ORIGIN, Z_MAX_NEG);
        orbit_point(Q_MINUS_TWO, 32'd0);
        drain_results();
        write_reg(REG_X_ORIGIN, Z_MAX_POS);
        write_reg(REG_Y_ORIGIN, Z_MAX_POS);
        orbit_point(Z_MAX_POS, Z_MAX_POS);
        read_bin(8'd0, 8'd0);
        drain_results();
        // unmapped addresses must leave every register alone
        write_reg(REG_SPARE_A, $urandom);
        write_reg(REG_SPARE_B, $urandom);
        orbit_point(Q_ONE, Q_ONE);
        drain_results();
    endtask

    task automatic test_random_traffic();
        int   pick;
        int   idx;
        logic [31:0] esc;
        for (int phase = 0; phase < 4; phase++) begin
            write_reg(REG_MAX_ITER, (phase == 0) ? 32'd2 : $urandom_range(8, 300));
            case (phase % 3)
                0:       esc = ESC_SIXTEEN;
                1:       esc = ESC_FOUR;
                default: esc = $urandom;
            endcase
            write_reg(REG_ESCAPE, esc);
            write_reg(REG_X_ORIGIN,
                      32'(X_ORIGIN_RST + $urandom_range(0, 32'h0200_0000) - 32'h0100_0000));
            write_reg(REG_Y_ORIGIN,
                      32'(Y_ORIGIN_RST + $urandom_range(0, 32'h0200_0000) - 32'h0100_0000));
            write_reg(REG_X_SCALE, $urandom_range(32'h0010_0000, 32'h0080_0000));
            write_reg(REG_Y_SCALE, $urandom_range(32'h0010_0000, 32'h0080_0000));
            steady = (phase == 2);
            repeat (19) begin
                pick = $urandom_range(99);
                if (pick < 55) begin
                    orbit_point(32'(int'($urandom_range(0, 13 << 24)) - (9 << 24)),
                                32'(int'($urandom_range(0, 6 << 24)) - (3 << 24)));
                end else if (pick < 70) begin
                    orbit_point($urandom, $urandom);
                end else if (visited_bins.size() != 0 && $urandom_range(99) < 80) begin
                    idx = visited_bins[$urandom_range(visited_bins.size() - 1)];
                    read_bin(8'(idx % HIST_COLS), 8'(idx / HIST_COLS));
                end else begin
                    read_bin(8'($urandom), 8'($urandom));
                end
            end
            drain_results();
            steady = 1'b0;
        end
    endtask

    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 30);
    end

    always @(posedge aclk) begin : check_results
        orbit_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: steps %0d escaped %0b count %0d",
                             m_steps_taken, m_escaped, m_bin_count);
            end else begin
                want = expected_results.pop_front();
                if (m_steps_taken !== want.steps || m_escaped !== want.escaped ||
                    m_bin_count !== want.count) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("mismatch: steps exp %0d got %0d, escaped exp %0b got %0b,",
                               want.steps, m_steps_taken, want.escaped, m_escaped);
                        $display(" count exp %0d got %0d", want.count, m_bin_count);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles = 0;
            else stall_cycles++;
        end
        $display("FAIL mandelbrot_orbit_histogram");
        $finish;
    end

    initial begin
        aclk         = 1'b0;
        aresetn      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        s_valid      = 1'b0;
        s_operation  = OP_ORBIT;
        s_c_real     = '0;
        s_c_imag     = '0;
        s_bin_column = '0;
        s_bin_row    = '0;
        m_ready      = 1'b0;
        steady       = 1'b0;
        mismatches   = 0;
        cfg_max_iter = MAX_ITER_RST;
        cfg_escape   = ESCAPE_RST;
        cfg_x_origin = X_ORIGIN_RST;
        cfg_y_origin = Y_ORIGIN_RST;
        cfg_x_scale  = X_SCALE_RST;
        cfg_y_scale  = Y_SCALE_RST;
        for (int i = 0; i < HIST_BINS; i++) bin_hist[i] = '0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_iteration_cap();
        test_escape_limit();
        test_grid_mapping();
        test_random_traffic();

        drain_results();
        repeat (20) @(negedge aclk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS mandelbrot_orbit_histogram");
        else
            $display("FAIL mandelbrot_orbit_histogram");
        $finish;
    end

endmodule
